FILE: design/cafp_pkg.sv
// ----------------------------------------------------------------------------
// cafp_pkg
// Shared types and constants of the ASCII CAN frame parser.
// ----------------------------------------------------------------------------
package cafp_pkg;

    localparam int unsigned DEFAULT_MAX_DATA_BYTES = 8;
    localparam int unsigned OUT_BYTES              = 8;
    localparam int unsigned OUT_DATA_BITS          = OUT_BYTES * 8;
    localparam int unsigned ID_BITS                = 32;
    localparam int unsigned ID_DIGITS_MAX          = 8;
    localparam int unsigned ID_CNT_W               = 4;
    localparam int unsigned NIB_CNT_W              = 5;
    localparam int unsigned COUNT_W                = 4;
    localparam int unsigned QUEUE_DEPTH            = 2;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_X     = 8'h58;
    localparam logic [7:0] CHAR_N     = 8'h4E;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;

    localparam logic [1:0] STATUS_GOOD    = 2'd0;
    localparam logic [1:0] STATUS_ID_LEN  = 2'd1;
    localparam logic [1:0] STATUS_DATA_LEN = 2'd2;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd3;

    typedef enum logic [2:0] {
        CLS_COLON,
        CLS_X,
        CLS_N,
        CLS_SEMI,
        CLS_HEX,
        CLS_OTHER
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  hex;
    } cafp_word_t;

endpackage

FILE: design/cafp_if.sv
// ----------------------------------------------------------------------------
// cafp_if
// Valid/ready channels of the ASCII CAN frame parser.
// ----------------------------------------------------------------------------
interface cafp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

interface cafp_frame_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] frame_id;
    logic [3:0]  data_count;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic [7:0]  byte7;

    modport source (
        output valid, output status, output frame_id, output data_count,
        output byte0, output byte1, output byte2, output byte3,
        output byte4, output byte5, output byte6, output byte7,
        input ready
    );
    modport sink (
        input valid, input status, input frame_id, input data_count,
        input byte0, input byte1, input byte2, input byte3,
        input byte4, input byte5, input byte6, input byte7,
        output ready
    );
endinterface

FILE: design/can_ascii_frame_parser.sv
// ----------------------------------------------------------------------------
// can_ascii_frame_parser
// Recognizes ASCII CAN frames and delivers the decoded id and data bytes.
// ----------------------------------------------------------------------------
// Usage:
// char_in carries one character per word. frame_out carries one result word
// for each frame closed by a semicolon after the N marker: status, id, byte
// count and eight data bytes, absent bytes zero. Error results carry zeros.
// A colon restarts the frame at any point; other text outside a frame and
// frames closed before the N marker give no result.
// The block accepts one character per cycle while char_in.ready is high. A
// character passes the classifier into a two-word queue and is consumed
// from it by the frame sequencer, which registers the result word when it
// consumes the closing semicolon.
// Reset clears the queue, the sequencer (hunting for a colon) and the
// result valid flag. When the receiver stalls, the result is held; the
// sequencer keeps consuming characters that do not close a frame, and the
// queue fills and drops char_in.ready only when a second result is waiting.
// ----------------------------------------------------------------------------
module can_ascii_frame_parser #(
    parameter int unsigned MAX_DATA_BYTES = cafp_pkg::DEFAULT_MAX_DATA_BYTES
) (
    input  logic          clk,
    input  logic          rst_n,
    cafp_char_if.sink     char_in,
    cafp_frame_if.source  frame_out
);
    import cafp_pkg::*;

    cafp_word_t front_word;
    cafp_word_t head_word;
    logic       push;
    logic       pop;
    logic       queue_full;
    logic       queue_not_empty;

    cafp_front u_front (
        .char_in    (char_in),
        .queue_full (queue_full),
        .push       (push),
        .word       (front_word)
    );

    cafp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (front_word),
        .pop       (pop),
        .head_word (head_word),
        .not_empty (queue_not_empty),
        .full      (queue_full)
    );

    cafp_back #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .word       (head_word),
        .word_valid (queue_not_empty),
        .word_pop   (pop),
        .frame_out  (frame_out)
    );

endmodule

FILE: design/cafp_front.sv
// ----------------------------------------------------------------------------
// cafp_front
// Accepts characters and classifies each one for the frame sequencer.
// ----------------------------------------------------------------------------
module cafp_front (
    cafp_char_if.sink          char_in,
    input  logic               queue_full,
    output logic               push,
    output cafp_pkg::cafp_word_t word
);
    import cafp_pkg::*;

    logic [7:0] c;

    assign c             = char_in.char_code;
    assign char_in.ready = !queue_full;
    assign push          = char_in.valid && !queue_full;

    always_comb
    begin
        word.hex = 4'd0;
        if (c == CHAR_COLON)
        begin
            word.cls = CLS_COLON;
        end
        else if (c == CHAR_X)
        begin
            word.cls = CLS_X;
        end
        else if (c == CHAR_N)
        begin
            word.cls = CLS_N;
        end
        else if (c == CHAR_SEMI)
        begin
            word.cls = CLS_SEMI;
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            word.cls = CLS_HEX;
            word.hex = c[3:0];
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            word.cls = CLS_HEX;
            word.hex = c[3:0] + 4'd9;
        end
        else
        begin
            word.cls = CLS_OTHER;
        end
    end

endmodule

FILE: design/cafp_queue.sv
// ----------------------------------------------------------------------------
// cafp_queue
// Short queue of classified words between the front and the sequencer.
// ----------------------------------------------------------------------------
module cafp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cafp_pkg::cafp_word_t push_word,
    input  logic                 pop,
    output cafp_pkg::cafp_word_t head_word,
    output logic                 not_empty,
    output logic                 full
);
    import cafp_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    cafp_word_t       mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign head_word = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue count exceeds depth");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");
`endif

endmodule

FILE: design/cafp_back.sv
// ----------------------------------------------------------------------------
// cafp_back
// Frame sequencer: accumulates id and data, and registers the result word.
// ----------------------------------------------------------------------------
module cafp_back #(
    parameter int unsigned MAX_DATA_BYTES = cafp_pkg::DEFAULT_MAX_DATA_BYTES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cafp_pkg::cafp_word_t word,
    input  logic                 word_valid,
    output logic                 word_pop,
    cafp_frame_if.source         frame_out
);
    import cafp_pkg::*;

    localparam int unsigned DATA_BITS = MAX_DATA_BYTES * 8;
    localparam logic [NIB_CNT_W-1:0] NIB_LIMIT = NIB_CNT_W'(2 * MAX_DATA_BYTES);
    localparam logic [ID_CNT_W-1:0] ID_MAX = ID_CNT_W'(ID_DIGITS_MAX);
    localparam logic [ID_CNT_W-1:0] ID_SAT = ID_CNT_W'(ID_DIGITS_MAX + 1);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_X    = 2'd1;
    localparam logic [1:0] PH_ID   = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

    logic [1:0]           phase_reg;
    logic [1:0]           phase_next;
    logic [ID_BITS-1:0]   id_acc_reg;
    logic [ID_BITS-1:0]   id_acc_next;
    logic [ID_CNT_W-1:0]  id_cnt_reg;
    logic [ID_CNT_W-1:0]  id_cnt_next;
    logic [NIB_CNT_W-1:0] nib_cnt_reg;
    logic [NIB_CNT_W-1:0] nib_cnt_next;
    logic [DATA_BITS-1:0] store_reg;
    logic [DATA_BITS-1:0] store_next;
    logic                 bad_reg;
    logic                 bad_next;

    logic                     out_valid_reg;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic [ID_BITS-1:0]       id_out_reg;
    logic [COUNT_W-1:0]       count_out_reg;
    logic [OUT_DATA_BITS-1:0] bytes_out_reg;
    logic                     emit;

    assign emit     = (phase_reg == PH_DATA) && (word.cls == CLS_SEMI);
    assign word_pop = word_valid && (!emit || !out_valid_reg || frame_out.ready);

    always_comb
    begin
        if (id_cnt_reg == '0 || id_cnt_reg > ID_MAX)
        begin
            status_next = STATUS_ID_LEN;
        end
        else if (nib_cnt_reg > NIB_LIMIT || nib_cnt_reg[0])
        begin
            status_next = STATUS_DATA_LEN;
        end
        else if (bad_reg)
        begin
            status_next = STATUS_BAD_CHAR;
        end
        else
        begin
            status_next = STATUS_GOOD;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        id_acc_next  = id_acc_reg;
        id_cnt_next  = id_cnt_reg;
        nib_cnt_next = nib_cnt_reg;
        store_next   = store_reg;
        bad_next     = bad_reg;
        if (word.cls == CLS_COLON)
        begin
            phase_next   = PH_X;
            id_acc_next  = '0;
            id_cnt_next  = '0;
            nib_cnt_next = '0;
            store_next   = '0;
            bad_next     = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                end
                PH_X:
                begin
                    phase_next = (word.cls == CLS_X) ? PH_ID : PH_HUNT;
                end
                PH_ID:
                begin
                    if (word.cls == CLS_N)
                    begin
                        phase_next = PH_DATA;
                    end
                    else if (word.cls == CLS_SEMI)
                    begin
                        phase_next   = PH_HUNT;
                        id_acc_next  = '0;
                        id_cnt_next  = '0;
                        nib_cnt_next = '0;
                        store_next   = '0;
                        bad_next     = 1'b0;
                    end
                    else
                    begin
                        if (word.cls != CLS_HEX)
                        begin
                            bad_next = 1'b1;
                        end
                        else if (id_cnt_reg < ID_MAX)
                        begin
                            id_acc_next = {id_acc_reg[ID_BITS-5:0], word.hex};
                        end
                        if (id_cnt_reg < ID_SAT)
                        begin
                            id_cnt_next = id_cnt_reg + 1'b1;
                        end
                    end
                end
                PH_DATA:
                begin
                    if (word.cls == CLS_SEMI)
                    begin
                        phase_next   = PH_HUNT;
                        id_acc_next  = '0;
                        id_cnt_next  = '0;
                        nib_cnt_next = '0;
                        store_next   = '0;
                        bad_next     = 1'b0;
                    end
                    else
                    begin
                        if (word.cls != CLS_HEX)
                        begin
                            bad_next = 1'b1;
                        end
                        else if (nib_cnt_reg < NIB_LIMIT)
                        begin
                            for (int b = 0; b < MAX_DATA_BYTES; b++)
                            begin
                                if (nib_cnt_reg[NIB_CNT_W-1:1] == (NIB_CNT_W-1)'(b))
                                begin
                                    if (nib_cnt_reg[0])
                                    begin
                                        store_next[b*8 +: 4] = word.hex;
                                    end
                                    else
                                    begin
                                        store_next[b*8+4 +: 4] = word.hex;
                                    end
                                end
                            end
                        end
                        if (nib_cnt_reg <= NIB_LIMIT)
                        begin
                            nib_cnt_next = nib_cnt_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            id_acc_reg    <= '0;
            id_cnt_reg    <= '0;
            nib_cnt_reg   <= '0;
            store_reg     <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (word_pop)
            begin
                phase_reg   <= phase_next;
                id_acc_reg  <= id_acc_next;
                id_cnt_reg  <= id_cnt_next;
                nib_cnt_reg <= nib_cnt_next;
                store_reg   <= store_next;
                bad_reg     <= bad_next;
            end
            if (word_pop && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (frame_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_pop && emit)
        begin
            status_reg <= status_next;
            if (status_next == STATUS_GOOD)
            begin
                id_out_reg    <= id_acc_reg;
                count_out_reg <= nib_cnt_reg[COUNT_W:1];
                bytes_out_reg <= OUT_DATA_BITS'(store_reg);
            end
            else
            begin
                id_out_reg    <= '0;
                count_out_reg <= '0;
                bytes_out_reg <= '0;
            end
        end
    end

    assign frame_out.valid      = out_valid_reg;
    assign frame_out.status     = status_reg;
    assign frame_out.frame_id   = id_out_reg;
    assign frame_out.data_count = count_out_reg;
    assign frame_out.byte0      = bytes_out_reg[7:0];
    assign frame_out.byte1      = bytes_out_reg[15:8];
    assign frame_out.byte2      = bytes_out_reg[23:16];
    assign frame_out.byte3      = bytes_out_reg[31:24];
    assign frame_out.byte4      = bytes_out_reg[39:32];
    assign frame_out.byte5      = bytes_out_reg[47:40];
    assign frame_out.byte6      = bytes_out_reg[55:48];
    assign frame_out.byte7      = bytes_out_reg[63:56];

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (word_pop && emit) |-> (!out_valid_reg || frame_out.ready))
        else $error("result word overwritten before it was taken");
    a_error_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != STATUS_GOOD) |->
        (id_out_reg == '0 && count_out_reg == '0 && bytes_out_reg == '0))
        else $error("error result carries payload");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> count_out_reg <= COUNT_W'(MAX_DATA_BYTES))
        else $error("data count exceeds maximum");
`endif

endmodule

FILE: tb/tb_can_ascii_frame_parser.sv
// ----------------------------------------------------------------------------
// tb_can_ascii_frame_parser
// Self-checking regression for the ASCII CAN frame parser.
// A short directed character stream opens the run, followed by random
// sequences. Most are well-formed frames with random content; the rest are
// frames broken in one or more fields and stretches of noise. Every accepted
// character updates a scoreboard that models the parser. Each accepted
// result word is compared field by field with the oldest predicted frame.
// The sender works in bursts and the receiver stalls on its own pattern.
// Twice the receiver holds off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module tb_can_ascii_frame_parser;

    import cafp_pkg::*;

    localparam int unsigned NIB_LIMIT    = 2 * DEFAULT_MAX_DATA_BYTES;
    localparam int unsigned RANDOM_CHARS = 1650;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned IDLE_LIMIT   = 5000;
    localparam int unsigned DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [1:0]      status;
        logic [31:0]     frame_id;
        logic [3:0]      data_count;
        logic [7:0][7:0] data;
    } frame_result_t;

    function automatic logic [4:0] hex_of(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return 5'(c - 8'h30);
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return 5'(c - 8'h41 + 8'd10);
        end
        return 5'd16;
    endfunction

    class frame_scoreboard;
        typedef enum logic [1:0] {
            SEEK_COLON,
            SEEK_X,
            IN_ID,
            IN_DATA
        } parse_phase_t;

        parse_phase_t    phase;
        logic [31:0]     id_acc;
        logic [3:0]      id_chars;
        logic [4:0]      data_chars;
        logic [63:0]     data_acc;
        bit              saw_bad_char;
        frame_result_t   expected_q[$];
        int unsigned     errors;

        function new();
            phase  = SEEK_COLON;
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            id_acc       = '0;
            id_chars     = '0;
            data_chars   = '0;
            data_acc     = '0;
            saw_bad_char = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void close_frame();
            frame_result_t res;
            res = '0;
            if (id_chars < 1 || id_chars > ID_DIGITS_MAX)
            begin
                res.status = STATUS_ID_LEN;
            end
            else if (data_chars > NIB_LIMIT || data_chars[0])
            begin
                res.status = STATUS_DATA_LEN;
            end
            else if (saw_bad_char)
            begin
                res.status = STATUS_BAD_CHAR;
            end
            else
            begin
                res.status     = STATUS_GOOD;
                res.frame_id   = id_acc;
                res.data_count = 4'(data_chars >> 1);
                for (int k = 0; k < 8; k++)
                begin
                    res.data[k] = data_acc[8 * k +: 8];
                end
            end
            expected_q.push_back(res);
            phase = SEEK_COLON;
            clear_frame();
        endfunction

        function void note_char(logic [7:0] c);
            logic [4:0] hx;
            int unsigned pos;
            hx = hex_of(c);
            if (c == CHAR_COLON)
            begin
                clear_frame();
                phase = SEEK_X;
                return;
            end
            case (phase)
                SEEK_X:
                begin
                    phase = (c == CHAR_X) ? IN_ID : SEEK_COLON;
                end
                IN_ID:
                begin
                    if (c == CHAR_N)
                    begin
                        phase = IN_DATA;
                    end
                    else if (c == CHAR_SEMI)
                    begin
                        phase = SEEK_COLON;
                        clear_frame();
                    end
                    else
                    begin
                        if (hx > 15)
                        begin
                            saw_bad_char = 1;
                        end
                        else if (id_chars < ID_DIGITS_MAX)
                        begin
                            id_acc = {id_acc[27:0], hx[3:0]};
                        end
                        if (id_chars < ID_DIGITS_MAX + 1)
                        begin
                            id_chars++;
                        end
                    end
                end
                IN_DATA:
                begin
                    if (c == CHAR_SEMI)
                    begin
                        close_frame();
                    end
                    else
                    begin
                        if (hx > 15)
                        begin
                            saw_bad_char = 1;
                        end
                        else if (data_chars < NIB_LIMIT)
                        begin
                            pos = (data_chars >> 1) * 8 + (data_chars[0] ? 0 : 4);
                            data_acc |= 64'(hx[3:0]) << pos;
                        end
                        if (data_chars <= NIB_LIMIT)
                        begin
                            data_chars++;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (exp_v !== got_v)
            begin
                $display("%0t: mismatch on %s: expected %0h, actual %0h",
                         $time, name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_frame(frame_result_t got);
            frame_result_t exp_r;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result word with none expected: actual status %0d id %0h count %0d",
                         $time, got.status, got.frame_id, got.data_count);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            compare_field("status", 32'(exp_r.status), 32'(got.status));
            compare_field("frame_id", exp_r.frame_id, got.frame_id);
            compare_field("data_count", 32'(exp_r.data_count), 32'(got.data_count));
            for (int k = 0; k < 8; k++)
            begin
                compare_field($sformatf("byte%0d", k), 32'(exp_r.data[k]), 32'(got.data[k]));
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    cafp_char_if  char_bus ();
    cafp_frame_if frame_bus ();

    can_ascii_frame_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_bus),
        .frame_out (frame_bus)
    );

    frame_scoreboard sb;
    bit              hold_req;
    int unsigned     burst_left;
    int unsigned     chars_sent;
    logic [7:0]      seq_q[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        frame_result_t got;
        if (rst_n)
        begin
            if (char_bus.valid && char_bus.ready)
            begin
                sb.note_char(char_bus.char_code);
            end
            if (frame_bus.valid && frame_bus.ready)
            begin
                got.status     = frame_bus.status;
                got.frame_id   = frame_bus.frame_id;
                got.data_count = frame_bus.data_count;
                got.data       = {frame_bus.byte7, frame_bus.byte6, frame_bus.byte5,
                                  frame_bus.byte4, frame_bus.byte3, frame_bus.byte2,
                                  frame_bus.byte1, frame_bus.byte0};
                sb.check_frame(got);
            end
        end
    end

    function automatic logic [7:0] hex_char(int unsigned v);
        return (v < 10) ? 8'(8'h30 + v) : 8'(8'h41 + v - 10);
    endfunction

    function automatic logic [7:0] nonhex_char(bit allow_n);
        logic [7:0]  c;
        int unsigned r;
        do
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
            begin
                c = 8'(8'h61 + $urandom_range(0, 5));
            end
            else if (r < 5)
            begin
                c = (allow_n && r == 4) ? CHAR_N : CHAR_X;
            end
            else
            begin
                c = 8'($urandom_range(0, 255));
            end
        end
        while (hex_of(c) < 16 || c == CHAR_COLON || c == CHAR_SEMI ||
               (!allow_n && c == CHAR_N));
        return c;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            seq_q.push_back(s[i]);
        end
    endfunction

    function automatic void build_sequence();
        int unsigned r;
        int unsigned id_len;
        int unsigned nib_len;
        int unsigned start;
        logic [7:0]  c;
        seq_q.delete();
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            repeat ($urandom_range(1, 8)) seq_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        seq_q.push_back(CHAR_COLON);
        if (r < 16)
        begin
            do
            begin
                c = 8'($urandom_range(0, 255));
            end
            while (c == CHAR_X || c == CHAR_COLON);
            seq_q.push_back(c);
            push_text("12N34;");
            return;
        end
        seq_q.push_back(CHAR_X);

        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            id_len = (r < 3) ? 0 : $urandom_range(9, 12);
        end
        else if (r < 25)
        begin
            id_len = 8;
        end
        else if (r < 35)
        begin
            id_len = 1;
        end
        else
        begin
            id_len = $urandom_range(1, 8);
        end
        start = seq_q.size();
        for (int i = 0; i < id_len; i++)
        begin
            seq_q.push_back(hex_char($urandom_range(0, 15)));
        end
        if (id_len > 0 && $urandom_range(0, 99) < 6)
        begin
            seq_q[$urandom_range(start, seq_q.size() - 1)] = nonhex_char(0);
        end
        if ($urandom_range(0, 99) < 5)
        begin
            seq_q.push_back(CHAR_SEMI);
            return;
        end
        seq_q.push_back(CHAR_N);

        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            nib_len = 2 * $urandom_range(0, 8) + 1;
        end
        else if (r < 10)
        begin
            nib_len = $urandom_range(17, 22);
        end
        else if (r < 25)
        begin
            nib_len = 16;
        end
        else if (r < 35)
        begin
            nib_len = 0;
        end
        else
        begin
            nib_len = 2 * $urandom_range(0, 8);
        end
        start = seq_q.size();
        for (int i = 0; i < nib_len; i++)
        begin
            seq_q.push_back(hex_char($urandom_range(0, 15)));
        end
        if (nib_len > 0 && $urandom_range(0, 99) < 6)
        begin
            seq_q[$urandom_range(start, seq_q.size() - 1)] = nonhex_char(1);
        end
        if ($urandom_range(0, 99) < 4)
        begin
            return;
        end
        seq_q.push_back(CHAR_SEMI);
    endfunction

    task automatic send_char(logic [7:0] c);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
            if (gap > 0)
            begin
                char_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= c;
        do
        begin
            @(posedge clk);
        end
        while (!char_bus.ready);
        chars_sent++;
    endtask

    task automatic send_queued();
        foreach (seq_q[i])
        begin
            send_char(seq_q[i]);
        end
    endtask

    initial
    begin
        int unsigned seq_count;
        sb                 = new();
        rst_n              = 1'b0;
        char_bus.valid     = 1'b0;
        char_bus.char_code = 8'h00;
        hold_req           = 0;
        burst_left         = 0;
        chars_sent         = 0;
        seq_count          = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        seq_q.delete();
        push_text(":X0N;:XN;:Q;:X7;");
        seq_q.push_back(8'h00);
        seq_q.push_back(8'hFF);
        push_text(";:X:XaN;");
        send_queued();

        while (chars_sent < RANDOM_CHARS)
        begin
            seq_count++;
            if (seq_count == 30 || seq_count == 80)
            begin
                hold_req = 1;
            end
            build_sequence();
            send_queued();
        end
        char_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("can_ascii_frame_parser regression: pass");
        end
        else
        begin
            $display("can_ascii_frame_parser regression: fail");
        end
        $finish;
    end

    initial
    begin
        logic [15:0] pattern;
        int unsigned step;
        frame_bus.ready = 1'b0;
        pattern         = 16'hFFFF;
        step            = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                frame_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (step % 48 == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: pattern = 16'hFFFF;
                        1: pattern = 16'($urandom);
                        2: pattern = 16'($urandom) | 16'($urandom);
                        default: pattern = 16'($urandom) & 16'($urandom);
                    endcase
                end
                frame_bus.ready <= pattern[step % 16];
                step++;
            end
        end
    end

    initial
    begin
        int unsigned idle;
        idle = 0;
        wait (rst_n);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((char_bus.valid && char_bus.ready) || (frame_bus.valid && frame_bus.ready))
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
        end
        $display("%0t: no word accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("can_ascii_frame_parser regression: fail");
        $finish;
    end

endmodule
